/* rtl/mhpq_pkg.sv */
package mhpq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_DECREASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] vertex_id;
    logic signed [31:0] key_value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] popped_vertex;
    logic        found;
    logic        queue_empty;
    logic [1:0]  status;
  } rsp_t;

  // Entry as stored in the heap memory.
  typedef struct packed {
    logic [15:0]        vertex;
    logic signed [31:0] key;
  } entry_t;

endpackage

/* rtl/mhpq_store.sv */
// Heap storage with one write port and one read port, and registered read data.
module mhpq_store #(
  parameter int AW = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mhpq_pkg::entry_t    wdata,
  input  logic [AW-1:0]       raddr,
  output mhpq_pkg::entry_t    rdata
);

  mhpq_pkg::entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/min_heap_priority_queue_top.sv */
// From the accepting edge to the done strobe: push sifts the new entry up one level per
// compare; pop takes the root and the tail entry, then sifts the tail down; contains scans
// the entries in storage order; decrease_key runs the scan followed by the push sift-up;
// a refused push or pop goes straight to the response. The heap memory has separate read
// and write ports, with one read and one write per cycle. One transaction at a time: busy stays high
// until done, and the next transaction can be accepted at the edge that ends the done cycle.
// Reset clears the entry count, the sequencer and done; heap memory is not cleared.
// The result is shown for one cycle on done; the receiver cannot stall.
module min_heap_priority_queue_top #(
  parameter int HEAP_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mhpq_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done,
  output mhpq_pkg::rsp_t     rsp
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

  // Sift-up: S_UP_RD fetches the parent, S_UP_CMP compares and moves it down.
  // Pop: S_POP_ROOT takes the root vertex, S_POP_TAIL takes the tail entry.
  // Sift-down: read left, read right, pick the smaller child, compare and move.
  // Scan: one entry checked per cycle with the next read already issued.
  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_POP_ROOT, S_POP_TAIL, S_DN_RDL, S_DN_RDR,
    S_DN_RCMP, S_DN_CMP, S_SC_CHK, S_RESP
  } state_t;

  state_t            state;
  mhpq_pkg::cmd_t    cur;
  logic [CW-1:0]     count;
  logic [CW-1:0]     pos;     // hole being sifted, or scan index
  logic [CW-1:0]     other;   // parent or chosen child, or next scan read
  mhpq_pkg::entry_t  ent_a;   // entry that travels with the hole
  mhpq_pkg::entry_t  ent_b;   // best child so far
  logic              found;
  logic [15:0]       popped;
  logic [1:0]        status;

  logic              we;
  logic [AW-1:0]     waddr;
  mhpq_pkg::entry_t  wdata;
  logic [AW-1:0]     raddr;
  mhpq_pkg::entry_t  rdata;

  mhpq_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Child indexes, kept one bit wider so they can be compared past count.
  logic [CW:0] left_idx, right_idx;
  assign left_idx  = {pos, 1'b1};
  assign right_idx = {pos, 1'b1} + (CW+1)'(1);

  logic [CW-1:0] parent_idx, tail_idx, pos_inc;
  assign parent_idx = (pos - CW'(1)) >> 1;
  assign tail_idx   = count - CW'(1);
  assign pos_inc    = pos + CW'(1);

  // Shared compare unit: signed key less-than, operands picked by state.
  logic signed [31:0] cmp_lhs, cmp_rhs;
  logic               less;
  always_comb begin
    cmp_lhs = ent_b.key;
    cmp_rhs = ent_a.key;
    unique case (state)
      S_UP_CMP: begin
        cmp_lhs = ent_a.key;
        cmp_rhs = rdata.key;
      end
      S_DN_RCMP: begin
        cmp_lhs = rdata.key;
        cmp_rhs = ent_b.key;
      end
      S_SC_CHK: begin
        cmp_lhs = cur.key_value;
        cmp_rhs = rdata.key;
      end
      default: ;
    endcase
    less = (cmp_lhs < cmp_rhs);
  end

  assign busy = (state != S_IDLE);

  // Memory port control; idle keeps the root read so pop and scan start at once.
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = ent_a;
    raddr = '0;
    unique case (state)
      S_UP_RD: begin
        // at the root: drop the travelling entry into place
        we    = (pos == '0);
        raddr = parent_idx[AW-1:0];
      end
      S_UP_CMP: begin
        // smaller: move the parent down into the hole, else settle here
        we    = 1'b1;
        wdata = less ? rdata : ent_a;
      end
      S_POP_ROOT: raddr = tail_idx[AW-1:0];
      S_DN_RDL: begin
        // no children left: settle the travelling entry
        we    = (left_idx >= {1'b0, count});
        raddr = left_idx[AW-1:0];
      end
      S_DN_RDR: raddr = right_idx[AW-1:0];
      S_DN_CMP: begin
        we    = 1'b1;
        wdata = less ? ent_b : ent_a;
      end
      S_SC_CHK: raddr = other[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      found  <= 1'b0;
      popped <= '0;
      status <= mhpq_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur    <= cmd;
            found  <= 1'b0;
            popped <= '0;
            status <= mhpq_pkg::ST_OK;
            pos    <= '0;
            other  <= CW'(1);
            unique case (cmd.operation)
              mhpq_pkg::OP_PUSH: begin
                if (count >= DEPTH_C) begin
                  status <= mhpq_pkg::ST_FULL;
                  state  <= S_RESP;
                end else begin
                  // open a hole at the tail and sift it up
                  ent_a <= '{vertex: cmd.vertex_id, key: cmd.key_value};
                  pos   <= count;
                  count <= count + CW'(1);
                  state <= S_UP_RD;
                end
              end
              mhpq_pkg::OP_POP: begin
                if (count == '0) begin
                  status <= mhpq_pkg::ST_EMPTY;
                  state  <= S_RESP;
                end else begin
                  state <= S_POP_ROOT;
                end
              end
              default: begin
                state <= (count == '0) ? S_RESP : S_SC_CHK;
              end
            endcase
          end
        end
        S_UP_RD: begin
          other <= parent_idx;
          state <= (pos == '0) ? S_RESP : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (less) begin
            pos   <= other;
            state <= S_UP_RD;
          end else begin
            state <= S_RESP;
          end
        end
        S_POP_ROOT: begin
          popped <= rdata.vertex;
          state  <= S_POP_TAIL;
        end
        S_POP_TAIL: begin
          // tail entry travels from the root downward
          ent_a <= rdata;
          count <= tail_idx;
          pos   <= '0;
          state <= (tail_idx == '0) ? S_RESP : S_DN_RDL;
        end
        S_DN_RDL: begin
          state <= (left_idx >= {1'b0, count}) ? S_RESP : S_DN_RDR;
        end
        S_DN_RDR: begin
          ent_b <= rdata;
          other <= left_idx[CW-1:0];
          state <= (right_idx < {1'b0, count}) ? S_DN_RCMP : S_DN_CMP;
        end
        S_DN_RCMP: begin
          // right child wins only when strictly smaller than the left
          if (less) begin
            ent_b <= rdata;
            other <= right_idx[CW-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (less) begin
            pos   <= other;
            state <= S_DN_RDL;
          end else begin
            state <= S_RESP;
          end
        end
        S_SC_CHK: begin
          if (rdata.vertex == cur.vertex_id) begin
            // first match in storage order decides
            found <= 1'b1;
            if ((cur.operation == mhpq_pkg::OP_DECREASE) && less) begin
              ent_a <= '{vertex: rdata.vertex, key: cur.key_value};
              state <= S_UP_RD;
            end else begin
              state <= S_RESP;
            end
          end else if (pos_inc >= count) begin
            state <= S_RESP;
          end else begin
            pos   <= pos_inc;
            other <= other + CW'(1);
          end
        end
        S_RESP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    rsp.popped_vertex = popped;
    rsp.found         = found;
    rsp.queue_empty   = (count == '0);
    rsp.status        = status;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("count overflow");

endmodule
